FILE: rtl/core/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Types, constants and the CORDIC angle table of the polar spiral pixel
// generator.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int IMG_WIDTH_DEF     = 240;
   localparam int IMG_HEIGHT_DEF    = 240;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int EASE_ENTRIES_DEF  = 256;

   localparam int RAD_BITS = 16;
   localparam int DXY_W    = 12;
   localparam int S_W      = 22;
   localparam int XY_W     = 34;
   localparam int ACC_W    = 56;
   localparam int B_W      = 40;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      CMD_RENDER = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_STRIPE    = 3'd0,
      REG_TWIST     = 3'd1,
      REG_INCREMENT = 3'd2,
      REG_DUTY      = 3'd3,
      REG_PRIMARY   = 3'd4,
      REG_SECONDARY = 3'd5,
      REG_BACKGND   = 3'd6,
      REG_MODE      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [7:0]  ease_index;
      logic [15:0] ease_value;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic        inside_circle;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         stripe_count;
      logic signed [15:0] twist_factor;
      logic [15:0]        phase_increment;
      logic [15:0]        duty_threshold;
      logic [15:0]        primary_color;
      logic [15:0]        secondary_color;
      logic [15:0]        background_color;
      logic [1:0]         mode_bits;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      cmd_type                command;
      logic                   in_circle;
      logic                   center;
      logic [7:0]             ease_index;
      logic [15:0]            ease_value;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [31:0]            z;
      logic [S_W-1:0]         s;
      logic [ACC_W-1:0]       a;
      logic [B_W-1:0]         b;
      logic [RAD_BITS-1:0]    r;
   } polar_type;

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/psg_csr.sv
// ----------------------------------------------------------------------------
// psg_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module psg_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [psg_pkg::ADDR_W-1:0]    paddr,
   input  logic [psg_pkg::DATA_W-1:0]    pwdata,
   output logic [psg_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output psg_pkg::cfg_type              cfg
);

   psg_pkg::cfg_type      cfg_ff;
   psg_pkg::reg_index_type reg_index;
   logic                  write_en;

   assign reg_index = psg_pkg::reg_index_type'(paddr[4:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stripe_count     <= 8'd8;
         cfg_ff.twist_factor     <= 16'sd768;
         cfg_ff.phase_increment  <= 16'd512;
         cfg_ff.duty_threshold   <= 16'd32767;
         cfg_ff.primary_color    <= 16'hFFFF;
         cfg_ff.secondary_color  <= 16'h0000;
         cfg_ff.background_color <= 16'h0000;
         cfg_ff.mode_bits        <= 2'd0;
      end else if (write_en) begin
         unique case (reg_index)
            psg_pkg::REG_STRIPE:    cfg_ff.stripe_count     <= pwdata[7:0];
            psg_pkg::REG_TWIST:     cfg_ff.twist_factor     <= $signed(pwdata[15:0]);
            psg_pkg::REG_INCREMENT: cfg_ff.phase_increment  <= pwdata[15:0];
            psg_pkg::REG_DUTY:      cfg_ff.duty_threshold   <= pwdata[15:0];
            psg_pkg::REG_PRIMARY:   cfg_ff.primary_color    <= pwdata[15:0];
            psg_pkg::REG_SECONDARY: cfg_ff.secondary_color  <= pwdata[15:0];
            psg_pkg::REG_BACKGND:   cfg_ff.background_color <= pwdata[15:0];
            psg_pkg::REG_MODE:      cfg_ff.mode_bits        <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         psg_pkg::REG_STRIPE:    prdata = {24'd0, cfg_ff.stripe_count};
         psg_pkg::REG_TWIST:     prdata = {16'd0, cfg_ff.twist_factor};
         psg_pkg::REG_INCREMENT: prdata = {16'd0, cfg_ff.phase_increment};
         psg_pkg::REG_DUTY:      prdata = {16'd0, cfg_ff.duty_threshold};
         psg_pkg::REG_PRIMARY:   prdata = {16'd0, cfg_ff.primary_color};
         psg_pkg::REG_SECONDARY: prdata = {16'd0, cfg_ff.secondary_color};
         psg_pkg::REG_BACKGND:   prdata = {16'd0, cfg_ff.background_color};
         psg_pkg::REG_MODE:      prdata = {30'd0, cfg_ff.mode_bits};
         default:                prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/psg_polar_stage.sv
// ----------------------------------------------------------------------------
// psg_polar_stage
// One pipeline stage of the CORDIC vectoring unit and of the bit-serial
// radius square root.
// ----------------------------------------------------------------------------
module psg_polar_stage #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = psg_pkg::CORDIC_STAGES_DEF,
   parameter int D2            = psg_pkg::IMG_WIDTH_DEF * psg_pkg::IMG_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  psg_pkg::polar_type  stage_prev,
   output psg_pkg::polar_type  stage_out
);

   localparam int K = (IDX < psg_pkg::RAD_BITS) ? psg_pkg::RAD_BITS - 1 - IDX : 0;
   localparam logic [psg_pkg::ACC_W-1:0] D2A = psg_pkg::ACC_W'(D2);
   localparam logic [psg_pkg::B_W-1:0]   D2B = psg_pkg::B_W'(D2);

   psg_pkg::polar_type stage_in;
   psg_pkg::polar_type stage_ff;
   logic               valid_ff;

   logic signed [psg_pkg::XY_W-1:0] xv;
   logic signed [psg_pkg::XY_W-1:0] yv;
   logic signed [psg_pkg::XY_W-1:0] xs;
   logic signed [psg_pkg::XY_W-1:0] ys;
   logic [psg_pkg::ACC_W-1:0]       trial;
   logic [psg_pkg::ACC_W-1:0]       target;

   assign xv     = stage_prev.x;
   assign yv     = stage_prev.y;
   assign xs     = xv >>> IDX;
   assign ys     = yv >>> IDX;
   assign trial  = stage_prev.a + (psg_pkg::ACC_W'(stage_prev.b) << (K + 1)) + (D2A << (2 * K));
   assign target = psg_pkg::ACC_W'({stage_prev.s, 32'd0});

   always_comb begin
      stage_in = stage_prev;
      if (IDX < CORDIC_STAGES) begin
         if (!yv[psg_pkg::XY_W-1]) begin
            stage_in.x = xv + ys;
            stage_in.y = yv - xs;
            stage_in.z = stage_prev.z + psg_pkg::atan_turn(IDX);
         end else begin
            stage_in.x = xv - ys;
            stage_in.y = yv + xs;
            stage_in.z = stage_prev.z - psg_pkg::atan_turn(IDX);
         end
      end
      if (IDX < psg_pkg::RAD_BITS) begin
         if (trial <= target) begin
            stage_in.a    = trial;
            stage_in.b    = stage_prev.b + (D2B << K);
            stage_in.r[K] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      stage_out       = stage_ff;
      stage_out.valid = valid_ff;
   end

endmodule

FILE: rtl/core/psg_color.sv
// ----------------------------------------------------------------------------
// psg_color
// Back end of the pipeline: easing table, stripe phase, frame offset and
// colour selection into the result register.
// ----------------------------------------------------------------------------
module psg_color #(
   parameter int EASE_ENTRIES = psg_pkg::EASE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  psg_pkg::polar_type  pol,
   input  psg_pkg::cfg_type    cfg,
   output logic                rsp_valid,
   output psg_pkg::rsp_type    rsp_data
);

   localparam int EW = (EASE_ENTRIES > 1) ? $clog2(EASE_ENTRIES) : 1;
   localparam int PW = psg_pkg::RAD_BITS + 11;
   localparam logic [7:0] WHEEL_THIRD = 8'd85;
   localparam logic [7:0] WHEEL_TWO   = 8'd170;

   function automatic logic [15:0] wheel_color(input logic [7:0] pos);
      logic [7:0] p;
      logic [7:0] q;
      logic [8:0] q3;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      p = 8'hFF - pos;
      if (p < WHEEL_THIRD) begin
         q = p;
      end else if (p < WHEEL_TWO) begin
         q = p - WHEEL_THIRD;
      end else begin
         q = p - WHEEL_TWO;
      end
      q3 = {q, 1'b0} + {1'b0, q};
      if (p < WHEEL_THIRD) begin
         r = 8'hFF - q3[7:0];
         g = 8'd0;
         b = q3[7:0];
      end else if (p < WHEEL_TWO) begin
         r = 8'd0;
         g = q3[7:0];
         b = 8'hFF - q3[7:0];
      end else begin
         r = q3[7:0];
         g = 8'hFF - q3[7:0];
         b = 8'd0;
      end
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // Stage A: final angle and table index.
   logic                         a_valid_ff;
   psg_pkg::cmd_type             a_cmd_ff;
   logic                         a_inside_ff;
   logic [31:0]                  a_angle_ff;
   logic [psg_pkg::RAD_BITS-1:0] a_rad_ff;
   logic [EW-1:0]                a_idx_ff;
   logic                         a_load_ok_ff;
   logic [EW-1:0]                a_waddr_ff;
   logic [15:0]                  a_wdata_ff;
   logic [PW-1:0]                idx_prod;
   logic [10:0]                  eidx_ext;

   // Stage B: table access.
   logic                         b_valid_ff;
   psg_pkg::cmd_type             b_cmd_ff;
   logic                         b_inside_ff;
   logic [31:0]                  b_angle_ff;
   logic [psg_pkg::RAD_BITS-1:0] b_rad_ff;
   logic [15:0]                  b_rd_ff;
   logic [15:0]                  ease_mem [EASE_ENTRIES];

   // Stage C: products.
   logic                         c_valid_ff;
   psg_pkg::cmd_type             c_cmd_ff;
   logic                         c_inside_ff;
   logic [31:0]                  c_ang_ff;
   logic [23:0]                  c_twist_ff;
   logic [15:0]                  eased;
   logic signed [32:0]           eased_s;
   logic signed [32:0]           twist_s;
   logic signed [32:0]           twist_prod;
   logic [39:0]                  ang_prod;

   // Stage D: phase.
   logic                         d_valid_ff;
   psg_pkg::cmd_type             d_cmd_ff;
   logic                         d_inside_ff;
   logic [15:0]                  d_phase_ff;
   logic [15:0]                  offset_ff;
   logic [31:0]                  comb_sum;

   // Stage E: result register.
   logic                         rsp_valid_ff;
   psg_pkg::rsp_type             rsp_data_ff;
   psg_pkg::rsp_type             rsp_data_in;

   assign idx_prod = PW'(pol.r) * PW'(EASE_ENTRIES);
   assign eidx_ext = 11'(pol.ease_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= pol.valid;
      end
      if (advance) begin
         a_cmd_ff     <= pol.command;
         a_inside_ff  <= pol.in_circle;
         a_angle_ff   <= pol.center ? 32'h80000000 : pol.z + 32'h80000000;
         a_rad_ff     <= pol.r;
         a_idx_ff     <= idx_prod[psg_pkg::RAD_BITS+EW-1:psg_pkg::RAD_BITS];
         a_load_ok_ff <= eidx_ext < 11'(EASE_ENTRIES);
         a_waddr_ff   <= eidx_ext[EW-1:0];
         a_wdata_ff   <= pol.ease_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_cmd_ff    <= a_cmd_ff;
         b_inside_ff <= a_inside_ff;
         b_angle_ff  <= a_angle_ff;
         b_rad_ff    <= a_rad_ff;
         b_rd_ff     <= ease_mem[a_idx_ff];
         if (a_valid_ff && a_cmd_ff == psg_pkg::CMD_LOAD && a_load_ok_ff) begin
            ease_mem[a_waddr_ff] <= a_wdata_ff;
         end
      end
   end

   assign eased      = cfg.mode_bits[1] ? b_rd_ff : b_rad_ff;
   assign eased_s    = $signed({17'd0, eased});
   assign twist_s    = 33'(cfg.twist_factor);
   assign twist_prod = eased_s * twist_s;
   assign ang_prod   = 40'(b_angle_ff) * 40'(cfg.stripe_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         c_cmd_ff    <= b_cmd_ff;
         c_inside_ff <= b_inside_ff;
         c_ang_ff    <= ang_prod[31:0];
         c_twist_ff  <= twist_prod[23:0];
      end
   end

   assign comb_sum = c_ang_ff + {c_twist_ff, 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         offset_ff  <= 16'd0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
         if (c_valid_ff && c_cmd_ff == psg_pkg::CMD_TICK) begin
            offset_ff <= offset_ff + cfg.phase_increment;
         end
      end
      if (advance) begin
         d_cmd_ff    <= c_cmd_ff;
         d_inside_ff <= c_inside_ff;
         d_phase_ff  <= comb_sum[31:16] + offset_ff;
      end
   end

   always_comb begin
      rsp_data_in.inside_circle = d_inside_ff;
      if (!d_inside_ff) begin
         rsp_data_in.pixel_color = cfg.background_color;
      end else if (d_phase_ff < cfg.duty_threshold) begin
         rsp_data_in.pixel_color = cfg.mode_bits[0] ? wheel_color(d_phase_ff[15:8])
                                                    : cfg.primary_color;
      end else begin
         rsp_data_in.pixel_color = cfg.secondary_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid_ff && d_cmd_ff == psg_pkg::CMD_RENDER;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/polar_spiral_pixel_generator.sv
// ----------------------------------------------------------------------------
// polar_spiral_pixel_generator
// Animated spiral pixel generator with an exact circle mask, CORDIC angle,
// square-root radius, easing table and RGB565 colour selection.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result is not stalled and
// returns one pixel per render request, in order; the pipeline depth is set by
// the CORDIC stages running beside the 16 stages of the radius root.
// Frame ticks and easing table loads travel through the same pipeline and
// return nothing. While a result is stalled, the whole pipeline holds. Load
// every easing table entry that a render can reach before enabling easing.
module polar_spiral_pixel_generator #(
   parameter int IMG_WIDTH     = psg_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT    = psg_pkg::IMG_HEIGHT_DEF,
   parameter int CORDIC_STAGES = psg_pkg::CORDIC_STAGES_DEF,
   parameter int EASE_ENTRIES  = psg_pkg::EASE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  psg_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output psg_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [psg_pkg::ADDR_W-1:0] paddr,
   input  logic [psg_pkg::DATA_W-1:0] pwdata,
   output logic [psg_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int DIAM = (IMG_WIDTH < IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
   localparam int D2   = DIAM * DIAM;
   localparam int NPOL = (CORDIC_STAGES > psg_pkg::RAD_BITS) ? CORDIC_STAGES
                                                              : psg_pkg::RAD_BITS;
   localparam logic signed [psg_pkg::DXY_W-1:0] XOFF = psg_pkg::DXY_W'(IMG_WIDTH - 1);
   localparam logic signed [psg_pkg::DXY_W-1:0] YOFF = psg_pkg::DXY_W'(IMG_HEIGHT - 1);
   localparam logic [psg_pkg::S_W-1:0]          D2S  = psg_pkg::S_W'(D2);

   psg_pkg::cfg_type cfg;
   logic             advance;

   logic                              f0_valid_ff;
   psg_pkg::cmd_type                  f0_cmd_ff;
   logic signed [psg_pkg::DXY_W-1:0]  f0_dx_ff;
   logic signed [psg_pkg::DXY_W-1:0]  f0_dy_ff;
   logic [7:0]                        f0_eidx_ff;
   logic [15:0]                       f0_eval_ff;

   logic signed [23:0]                sqx;
   logic signed [23:0]                sqy;
   logic [psg_pkg::S_W-1:0]           s_sum;
   logic signed [psg_pkg::XY_W-1:0]   x0;
   logic signed [psg_pkg::XY_W-1:0]   y0;
   psg_pkg::polar_type                pol0_in;
   psg_pkg::polar_type                pol0_ff;
   logic                              pol0_valid_ff;
   psg_pkg::polar_type                pol0_out;
   psg_pkg::polar_type                pol [NPOL+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   psg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else if (advance) begin
         f0_valid_ff <= req_valid;
      end
      if (advance) begin
         f0_cmd_ff  <= psg_pkg::cmd_type'(req_data.command);
         f0_dx_ff   <= $signed({3'd0, req_data.pixel_x, 1'b0}) - XOFF;
         f0_dy_ff   <= $signed({3'd0, req_data.pixel_y, 1'b0}) - YOFF;
         f0_eidx_ff <= req_data.ease_index;
         f0_eval_ff <= req_data.ease_value;
      end
   end

   assign sqx   = 24'(f0_dx_ff) * 24'(f0_dx_ff);
   assign sqy   = 24'(f0_dy_ff) * 24'(f0_dy_ff);
   assign s_sum = sqx[psg_pkg::S_W-1:0] + sqy[psg_pkg::S_W-1:0];
   assign x0    = psg_pkg::XY_W'($signed({f0_dx_ff, 20'd0}));
   assign y0    = psg_pkg::XY_W'($signed({f0_dy_ff, 20'd0}));

   always_comb begin
      pol0_in.valid      = f0_valid_ff;
      pol0_in.command    = f0_cmd_ff;
      pol0_in.in_circle  = s_sum <= D2S;
      pol0_in.center     = (f0_dx_ff == '0) && (f0_dy_ff == '0);
      pol0_in.ease_index = f0_eidx_ff;
      pol0_in.ease_value = f0_eval_ff;
      pol0_in.s          = s_sum;
      pol0_in.a          = '0;
      pol0_in.b          = '0;
      pol0_in.r          = '0;
      if (f0_dx_ff[psg_pkg::DXY_W-1]) begin
         pol0_in.x = -x0;
         pol0_in.y = -y0;
         pol0_in.z = 32'h80000000;
      end else begin
         pol0_in.x = x0;
         pol0_in.y = y0;
         pol0_in.z = 32'h00000000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pol0_valid_ff <= 1'b0;
      end else if (advance) begin
         pol0_valid_ff <= pol0_in.valid;
      end
      if (advance) begin
         pol0_ff <= pol0_in;
      end
   end

   always_comb begin
      pol0_out       = pol0_ff;
      pol0_out.valid = pol0_valid_ff;
   end

   assign pol[0] = pol0_out;

   for (genvar g = 0; g < NPOL; g++) begin : g_polar
      psg_polar_stage #(
         .IDX           (g),
         .CORDIC_STAGES (CORDIC_STAGES),
         .D2            (D2)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .stage_prev (pol[g]),
         .stage_out  (pol[g+1])
      );
   end

   psg_color #(
      .EASE_ENTRIES (EASE_ENTRIES)
   ) u_color (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pol       (pol[NPOL]),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_reset_clears_result: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(f0_valid_ff) && $stable(pol0_valid_ff))
      else $error("Front stages moved while the result was stalled.");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(pol[NPOL].valid))
      else $error("Polar pipeline moved while the result was stalled.");

endmodule
